>>> design/rc4_pkg.sv
// Shared types and constants for the RC4 keystream XOR block.
// Used by the permutation RAM, the sequencer and the top level; no dependencies.
package rc4_pkg;

    localparam int BYTE_W        = 8;
    localparam int PERM_DEPTH    = 256;
    localparam int PERM_AW       = $clog2(PERM_DEPTH);
    localparam int KEY_WORDS     = 4;
    localparam int KEY_WORD_W    = 64;
    localparam int KEY_LEN_W     = 6;
    localparam int KEY_IDX_W     = 5;
    localparam int MAX_KEY_BYTES = 32;
    localparam int CFG_IDX_W     = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_SECOND = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_THIRD  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH = 3'd4;

    typedef logic [KEY_WORDS-1:0][KEY_WORD_W-1:0] key_t;

    typedef struct packed {
        logic               we;
        logic [PERM_AW-1:0] waddr;
        logic [BYTE_W-1:0]  wdata;
        logic [PERM_AW-1:0] raddr0;
        logic [PERM_AW-1:0] raddr1;
    } ram_req_t;

    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data;
    } result_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_K0,
        ST_K1,
        ST_K2,
        ST_K3,
        ST_G0,
        ST_G1,
        ST_G2,
        ST_G3,
        ST_HOLD
    } state_t;

endpackage

>>> design/rc4_ram.sv
// 256 x 8 permutation memory: one write port, two read ports, registered read-first data.
// Depends on rc4_pkg.
module rc4_ram (
    input  logic                               aclk,
    input  rc4_pkg::ram_req_t                  req,
    output logic [rc4_pkg::BYTE_W-1:0]         rdata0,
    output logic [rc4_pkg::BYTE_W-1:0]         rdata1
);

    logic [rc4_pkg::BYTE_W-1:0] mem [rc4_pkg::PERM_DEPTH];

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
        rdata0 <= mem[req.raddr0];
        rdata1 <= mem[req.raddr1];
    end

endmodule

>>> design/rc4_seq.sv
// Sequencer for key scheduling and keystream generation around one shared 8-bit adder.
// Depends on rc4_pkg; drives rc4_ram through a request struct.
module rc4_seq #(
    parameter int MAX_KEY_BYTES = rc4_pkg::MAX_KEY_BYTES
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [rc4_pkg::BYTE_W-1:0]        in_data,
    input  logic                              in_start,
    input  logic                              out_ready,
    output rc4_pkg::result_t                  result,
    input  rc4_pkg::key_t                     key,
    input  logic [rc4_pkg::KEY_LEN_W-1:0]     key_len,
    output rc4_pkg::ram_req_t                 ram_req,
    input  logic [rc4_pkg::BYTE_W-1:0]        rdata0,
    input  logic [rc4_pkg::BYTE_W-1:0]        rdata1
);

    localparam int BW = rc4_pkg::BYTE_W;
    localparam logic [rc4_pkg::KEY_LEN_W-1:0] LEN_MAX =
        rc4_pkg::KEY_LEN_W'(MAX_KEY_BYTES);
    localparam logic [rc4_pkg::PERM_AW-1:0] LAST_ADDR =
        rc4_pkg::PERM_AW'(rc4_pkg::PERM_DEPTH - 1);

    rc4_pkg::state_t state_reg, state_next;

    logic [BW-1:0] a_reg, a_next;
    logic [rc4_pkg::KEY_IDX_W-1:0] kidx_reg, kidx_next;
    logic [BW-1:0] i_reg, i_next;
    logic [BW-1:0] j_reg, j_next;
    logic          keyed_reg, keyed_next;
    logic [BW-1:0] data_reg, data_next;
    logic [BW-1:0] sa_reg, sa_next;
    logic [BW-1:0] sb_reg, sb_next;
    logic [BW-1:0] t_reg, t_next;
    logic [BW-1:0] res_reg, res_next;

    // Shared adder and its operands.
    logic [BW-1:0] op_a, op_b, op_c, sum;
    logic [BW-1:0] key_byte;
    logic [BW-1:0] ks;
    logic [rc4_pkg::KEY_LEN_W-1:0] len_eff;
    logic          accept;
    logic          kidx_wrap;

    assign sum = op_a + op_b + op_c;
    assign key_byte = key[kidx_reg[rc4_pkg::KEY_IDX_W-1:3]][kidx_reg[2:0]*8 +: 8];
    assign accept = in_valid && in_ready;

    always_comb begin
        len_eff = key_len;
        if (key_len == '0) begin
            len_eff = rc4_pkg::KEY_LEN_W'(1);
        end else if (key_len > LEN_MAX) begin
            len_eff = LEN_MAX;
        end
    end

    assign kidx_wrap = ({1'b0, kidx_reg} == (len_eff - rc4_pkg::KEY_LEN_W'(1)));

    // Keystream byte after the swap, with both pending writes forwarded.
    always_comb begin
        if (t_reg == i_reg) begin
            ks = sb_reg;
        end else if (t_reg == j_reg) begin
            ks = sa_reg;
        end else begin
            ks = rdata0;
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            rc4_pkg::ST_IDLE, rc4_pkg::ST_G3, rc4_pkg::ST_HOLD: begin
                if (state_reg == rc4_pkg::ST_G3 && !out_ready) begin
                    state_next = rc4_pkg::ST_HOLD;
                end else if (accept) begin
                    state_next = (in_start || !keyed_reg) ? rc4_pkg::ST_INIT : rc4_pkg::ST_G0;
                end else if (state_reg != rc4_pkg::ST_HOLD || out_ready) begin
                    state_next = rc4_pkg::ST_IDLE;
                end
            end
            rc4_pkg::ST_INIT: if (a_reg == LAST_ADDR) state_next = rc4_pkg::ST_K0;
            rc4_pkg::ST_K0:   state_next = rc4_pkg::ST_K1;
            rc4_pkg::ST_K1:   state_next = rc4_pkg::ST_K2;
            rc4_pkg::ST_K2:   state_next = rc4_pkg::ST_K3;
            rc4_pkg::ST_K3:   state_next = (a_reg == LAST_ADDR) ? rc4_pkg::ST_G0 : rc4_pkg::ST_K0;
            rc4_pkg::ST_G0:   state_next = rc4_pkg::ST_G1;
            rc4_pkg::ST_G1:   state_next = rc4_pkg::ST_G2;
            rc4_pkg::ST_G2:   state_next = rc4_pkg::ST_G3;
            default:          state_next = rc4_pkg::ST_IDLE;
        endcase
    end

    // Outputs: memory requests, adder operands, handshakes.
    always_comb begin
        ram_req      = '0;
        op_a         = '0;
        op_b         = '0;
        op_c         = '0;
        in_ready     = 1'b0;
        result.valid = 1'b0;
        result.data  = data_reg ^ ks;
        case (state_reg)
            rc4_pkg::ST_IDLE: in_ready = 1'b1;
            rc4_pkg::ST_INIT: begin
                ram_req.we    = 1'b1;
                ram_req.waddr = a_reg;
                ram_req.wdata = a_reg;
                op_a = a_reg;
                op_b = BW'(1);
            end
            rc4_pkg::ST_K0: ram_req.raddr0 = a_reg;
            rc4_pkg::ST_K1: begin
                op_a = j_reg;
                op_b = rdata0;
                op_c = key_byte;
                ram_req.raddr1 = sum;
            end
            rc4_pkg::ST_K2: begin
                ram_req.we    = 1'b1;
                ram_req.waddr = a_reg;
                ram_req.wdata = rdata1;
            end
            rc4_pkg::ST_K3: begin
                ram_req.we    = 1'b1;
                ram_req.waddr = j_reg;
                ram_req.wdata = sa_reg;
                op_a = a_reg;
                op_b = BW'(1);
            end
            rc4_pkg::ST_G0: begin
                op_a = i_reg;
                op_b = BW'(1);
                ram_req.raddr0 = sum;
            end
            rc4_pkg::ST_G1: begin
                op_a = j_reg;
                op_b = rdata0;
                ram_req.raddr1 = sum;
            end
            rc4_pkg::ST_G2: begin
                ram_req.we    = 1'b1;
                ram_req.waddr = i_reg;
                ram_req.wdata = rdata1;
                op_a = sa_reg;
                op_b = rdata1;
                ram_req.raddr0 = sum;
            end
            rc4_pkg::ST_G3: begin
                ram_req.we    = 1'b1;
                ram_req.waddr = j_reg;
                ram_req.wdata = sa_reg;
                result.valid  = out_ready;
                in_ready      = out_ready;
            end
            rc4_pkg::ST_HOLD: begin
                result.valid = out_ready;
                result.data  = res_reg;
                in_ready     = out_ready;
            end
            default: ;
        endcase
    end

    // Datapath next values.
    always_comb begin
        a_next     = a_reg;
        kidx_next  = kidx_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        keyed_next = keyed_reg;
        data_next  = data_reg;
        sa_next    = sa_reg;
        sb_next    = sb_reg;
        t_next     = t_reg;
        res_next   = res_reg;
        case (state_reg)
            rc4_pkg::ST_INIT: a_next = sum;
            rc4_pkg::ST_K1: begin
                j_next  = sum;
                sa_next = rdata0;
            end
            rc4_pkg::ST_K3: begin
                a_next    = sum;
                kidx_next = kidx_wrap ? '0 : kidx_reg + rc4_pkg::KEY_IDX_W'(1);
                if (a_reg == LAST_ADDR) begin
                    i_next     = '0;
                    j_next     = '0;
                    keyed_next = 1'b1;
                end
            end
            rc4_pkg::ST_G0: i_next = sum;
            rc4_pkg::ST_G1: begin
                j_next  = sum;
                sa_next = rdata0;
            end
            rc4_pkg::ST_G2: begin
                sb_next = rdata1;
                t_next  = sum;
            end
            rc4_pkg::ST_G3: res_next = data_reg ^ ks;
            default: ;
        endcase
        if (accept) begin
            data_next = in_data;
            if (in_start || !keyed_reg) begin
                a_next    = '0;
                j_next    = '0;
                kidx_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rc4_pkg::ST_IDLE;
            keyed_reg <= 1'b0;
            i_reg     <= '0;
            j_reg     <= '0;
        end else begin
            state_reg <= state_next;
            keyed_reg <= keyed_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
        end
        a_reg     <= a_next;
        kidx_reg  <= kidx_next;
        data_reg  <= data_next;
        sa_reg    <= sa_next;
        sb_reg    <= sb_next;
        t_reg     <= t_next;
        res_reg   <= res_next;
    end

endmodule

>>> design/rc4_keystream_xor.sv
// RC4 keystream XOR: one data byte in, the byte XOR the next keystream byte out.
// A new byte is taken only as the previous result leaves the sequencer. Unless the result
// stalls, the pace is set by the four memory steps of the swap on the single-write-port permutation RAM.
// A start-of-message item (or the first item after reset) first fills the permutation and
// then runs its 256 key-scheduling swaps.
// Reset (aresetn, synchronous, active low) clears the handshake, indices and keyed flag,
// sets the key registers to zero and the key length to one.
module rc4_keystream_xor #(
    parameter int MAX_KEY_BYTES = rc4_pkg::MAX_KEY_BYTES
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Input stream.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // [7:0] data_byte
    input  logic [0:0]                        s_tuser,   // [0] start_of_message
    // Result stream.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [7:0]                        m_tdata,   // [7:0] out_byte
    // Configuration write channel.
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rc4_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rc4_pkg::KEY_WORD_W-1:0]    cfg_data
);

    rc4_pkg::key_t                  key_reg;
    logic [rc4_pkg::KEY_LEN_W-1:0]  key_len_reg;
    logic                           m_tvalid_reg;
    logic [rc4_pkg::BYTE_W-1:0]     m_tdata_reg;
    logic                           out_free;
    rc4_pkg::result_t               result;
    rc4_pkg::ram_req_t              ram_req;
    logic [rc4_pkg::BYTE_W-1:0]     rdata0;
    logic [rc4_pkg::BYTE_W-1:0]     rdata1;

    // Configuration is always taken; writes to unknown indexes are dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg     <= '0;
            key_len_reg <= rc4_pkg::KEY_LEN_W'(1);
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                rc4_pkg::CFG_KEY_LOW:    key_reg[0]  <= cfg_data;
                rc4_pkg::CFG_KEY_SECOND: key_reg[1]  <= cfg_data;
                rc4_pkg::CFG_KEY_THIRD:  key_reg[2]  <= cfg_data;
                rc4_pkg::CFG_KEY_HIGH:   key_reg[3]  <= cfg_data;
                rc4_pkg::CFG_KEY_LENGTH: key_len_reg <= cfg_data[rc4_pkg::KEY_LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // The output register frees the sequencer: the next item may start while a result
    // still waits here. The slot can take a new result when empty or draining this cycle.
    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (result.valid) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
        if (result.valid) begin
            m_tdata_reg <= result.data;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    rc4_seq #(
        .MAX_KEY_BYTES (MAX_KEY_BYTES)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (s_tdata),
        .in_start  (s_tuser[0]),
        .out_ready (out_free),
        .result    (result),
        .key       (key_reg),
        .key_len   (key_len_reg),
        .ram_req   (ram_req),
        .rdata0    (rdata0),
        .rdata1    (rdata1)
    );

    rc4_ram u_ram (
        .aclk   (aclk),
        .req    (ram_req),
        .rdata0 (rdata0),
        .rdata1 (rdata1)
    );

endmodule

>>> design/rc4_chk.sv
// Port-level checker for rc4_keystream_xor and its bind statement.
// Depends only on the top level's ports.
module rc4_chk (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);

    // Reset empties the result register.
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A stalled result holds.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // One item at a time: no transfer in the cycle after a transfer.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after a transfer");

    // A result cannot appear sooner than the generation steps allow.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> ##1 !$rose(m_tvalid))
        else $error("result too early");

endmodule

bind rc4_keystream_xor rc4_chk u_rc4_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

>>> bench/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for rc4_keystream_xor: a directed table, then random messages.
// Each output byte is checked against a typed-in vector or the bench's RC4 predictor.
// Depends on rc4_pkg and the rc4_keystream_xor RTL.

module testbench;

    localparam int HALF_PERIOD   = 5;
    localparam int RESET_CYCLES  = 10;
    localparam int RANDOM_ITEMS  = 450;
    localparam int QUIET_ITEMS   = 60;
    localparam int HOLD_AT_ITEM  = 120;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 16;
    localparam int MAX_REPORTS   = 10;
    // The slowest legal run keys every item and adds the worst gaps and stalls; this limit
    // is several times that run's length.
    localparam int CYCLE_LIMIT   = 3_000_000;

    // Register indexes past the end of the list; writes to them must be ignored.
    localparam logic [rc4_pkg::CFG_IDX_W-1:0] CFG_SPARE_FIRST =
        rc4_pkg::CFG_KEY_LENGTH + 1'b1;
    localparam logic [rc4_pkg::CFG_IDX_W-1:0] CFG_SPARE_LAST  = '1;

    typedef enum logic {
        STEP_BYTE,
        STEP_WRITE
    } step_kind_t;

    // One row of the directed table: either a register write or a data byte, with the
    // output byte typed in where it is a published RC4 vector.
    typedef struct packed {
        step_kind_t                         kind;
        logic [rc4_pkg::CFG_IDX_W-1:0]      reg_idx;
        logic [rc4_pkg::KEY_WORD_W-1:0]     reg_val;
        logic [7:0]                         din;
        logic                               som;
        logic                               known;
        logic [7:0]                         dout;
    } step_t;

    logic                               aclk;
    logic                               aresetn;
    logic                               s_tvalid;
    logic                               s_tready;
    logic [7:0]                         s_tdata;   // [7:0] data_byte
    logic [0:0]                         s_tuser;   // [0] start_of_message
    logic                               m_tvalid;
    logic                               m_tready;
    logic [7:0]                         m_tdata;   // [7:0] out_byte
    logic                               cfg_valid;
    logic                               cfg_ready;
    logic [rc4_pkg::CFG_IDX_W-1:0]      cfg_index;
    logic [rc4_pkg::KEY_WORD_W-1:0]     cfg_data;

    // Predictor state: the permutation, both indices, the keyed flag and a copy of the
    // key registers as the block should hold them.
    logic [7:0]                         sbox [rc4_pkg::PERM_DEPTH];
    logic [7:0]                         sbox_i;
    logic [7:0]                         sbox_j;
    logic                               keyed;
    logic [rc4_pkg::KEY_WORD_W-1:0]     key_word [rc4_pkg::KEY_WORDS];
    logic [rc4_pkg::KEY_LEN_W-1:0]      key_len;

    // Output bytes still owed by the block, oldest first.
    logic [7:0]              pending_out [$];
    step_t                   directed_tab [$];

    int                      errors;
    int                      reported;
    int                      cycle_count;
    int                      items_sent;
    bit                      rx_stalls;
    bit                      hold_request;
    bit                      pressure_arm;
    logic [7:0]              want_byte;

    rc4_keystream_xor u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial aclk = 1'b0;
    always #HALF_PERIOD aclk = ~aclk;

    // Advances the predictor by one accepted byte and returns the byte the block must emit.
    // A start of message, or any byte before the first schedule, reruns key scheduling.
    function automatic logic [7:0] cipher_byte(input logic [7:0] din, input logic som);
        int         n;
        int         k;
        logic [7:0] b;
        logic [7:0] t;
        logic [7:0] sidx;
        if (som || !keyed) begin
            // Length zero acts as one, and lengths past the key store saturate.
            n = int'(key_len);
            if (n == 0)
                n = 1;
            if (n > rc4_pkg::MAX_KEY_BYTES)
                n = rc4_pkg::MAX_KEY_BYTES;
            for (int a = 0; a < rc4_pkg::PERM_DEPTH; a++)
                sbox[a] = 8'(a);
            b = '0;
            for (int a = 0; a < rc4_pkg::PERM_DEPTH; a++) begin
                k = a % n;
                b = b + sbox[a] + key_word[k / 8][8 * (k % 8) +: 8];
                t = sbox[a];
                sbox[a] = sbox[b];
                sbox[b] = t;
            end
            sbox_i = '0;
            sbox_j = '0;
            keyed  = 1'b1;
        end
        sbox_i = sbox_i + 8'd1;
        sbox_j = sbox_j + sbox[sbox_i];
        t = sbox[sbox_i];
        sbox[sbox_i] = sbox[sbox_j];
        sbox[sbox_j] = t;
        sidx = sbox[sbox_i] + sbox[sbox_j];
        return din ^ sbox[sidx];
    endfunction

    // Offers one byte on the input stream. It is entered and left at a falling edge; on
    // return tvalid is still high, so the caller either offers the next byte at once or
    // lowers tvalid before doing anything else.
    task automatic push_byte(input logic [7:0] din, input logic som, input logic [7:0] fixed_out,
                             input bit fixed, input bit gaps);
        logic [7:0] predicted;
        if (gaps && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= din;
        s_tuser  <= som;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        predicted = cipher_byte(din, som);
        pending_out.push_back(fixed ? fixed_out : predicted);
        items_sent++;
        if (pressure_arm) begin
            pressure_arm = 1'b0;
            hold_request = 1'b1;
        end
        @(negedge aclk);
    endtask

    // Writes one register once the block has drained, then mirrors it in the predictor.
    task automatic write_reg(input logic [rc4_pkg::CFG_IDX_W-1:0] idx,
                             input logic [rc4_pkg::KEY_WORD_W-1:0] val);
        s_tvalid <= 1'b0;
        while (pending_out.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        case (idx)
            rc4_pkg::CFG_KEY_LOW, rc4_pkg::CFG_KEY_SECOND,
            rc4_pkg::CFG_KEY_THIRD, rc4_pkg::CFG_KEY_HIGH: begin
                key_word[idx[1:0]] = val;
            end
            rc4_pkg::CFG_KEY_LENGTH: begin
                key_len = val[rc4_pkg::KEY_LEN_W-1:0];
            end
            default: begin
            end
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic report_fail(input string msg);
        errors++;
        if (reported < MAX_REPORTS)
            $display("%s", msg);
        reported++;
    endtask

    // Stimulus: reset, the directed table, then random messages.
    initial begin
        step_t                          row;
        int                             rnd_done;
        int                             msg_len;
        int                             len_pick;
        bit                             gaps;
        bit                             quiet;
        bit                             first_som;
        bit                             som;
        bit                             pressure_done;
        bit                             pressure_phase;
        logic [rc4_pkg::CFG_IDX_W-1:0]  idx;
        logic [rc4_pkg::KEY_WORD_W-1:0] val;

        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = '0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        errors       = 0;
        reported     = 0;
        items_sent   = 0;
        rx_stalls    = 1'b1;
        hold_request = 1'b0;
        pressure_arm = 1'b0;
        rnd_done     = 0;
        pressure_done = 1'b0;

        // Predictor after reset: key cleared, length one, nothing scheduled yet.
        foreach (key_word[w])
            key_word[w] = '0;
        key_len = rc4_pkg::KEY_LEN_W'(1);
        sbox_i  = '0;
        sbox_j  = '0;
        keyed   = 1'b0;

        directed_tab = '{
            // No schedule has run yet, so the first byte keys with the reset key even
            // though it is not flagged as a start of message.
            '{STEP_BYTE,  rc4_pkg::CFG_KEY_LOW,    64'h0,       8'h00, 1'b0, 1'b0, 8'h00},
            '{STEP_BYTE,  rc4_pkg::CFG_KEY_LOW,    64'h0,       8'hFF, 1'b0, 1'b0, 8'h00},
            // The key "Key" and the plaintext "Plaintext" give the published ciphertext.
            '{STEP_WRITE, rc4_pkg::CFG_KEY_LOW,    64'h79_654B, 8'h00, 1'b0, 1'b0, 8'h00},
            '{STEP_WRITE, rc4_pkg::CFG_KEY_LENGTH, 64'd3,       8'h00, 1'b0, 1'b0, 8'h00},
            '{STEP_BYTE,  rc4_pkg::CFG_KEY_LOW,    64'h0,       8'h50, 1'b1, 1'b1, 8'hBB},
            '{STEP_BYTE,  rc4_pkg::CFG_KEY_LOW,    64'h0,       8'h6C, 1'b0, 1'b1, 8'hF3},
            '{STEP_BYTE,  rc4_pkg::CFG_KEY_LOW,    64'h0,       8'h61, 1'b0, 1'b1, 8'h16},
            '{STEP_BYTE,  rc4_pkg::CFG_KEY_LOW,    64'h0,       8'h69, 1'b0, 1'b1, 8'hE8},
            '{STEP_BYTE,  rc4_pkg::CFG_KEY_LOW,    64'h0,       8'h6E, 1'b0, 1'b1, 8'hD9},
            '{STEP_BYTE,  rc4_pkg::CFG_KEY_LOW,    64'h0,       8'h74, 1'b0, 1'b1, 8'h40},
            '{STEP_BYTE,  rc4_pkg::CFG_KEY_LOW,    64'h0,       8'h65, 1'b0, 1'b1, 8'hAF},
            '{STEP_BYTE,  rc4_pkg::CFG_KEY_LOW,    64'h0,       8'h78, 1'b0, 1'b1, 8'h0A},
            '{STEP_BYTE,  rc4_pkg::CFG_KEY_LOW,    64'h0,       8'h74, 1'b0, 1'b1, 8'hD3},
            // A key written mid-message must not disturb the running keystream.
            '{STEP_WRITE, rc4_pkg::CFG_KEY_LOW,    '1,          8'h00, 1'b0, 1'b0, 8'h00},
            '{STEP_BYTE,  rc4_pkg::CFG_KEY_LOW,    64'h0,       8'h5A, 1'b0, 1'b0, 8'h00},
            // All key bytes set, full key length.
            '{STEP_WRITE, rc4_pkg::CFG_KEY_SECOND, '1,          8'h00, 1'b0, 1'b0, 8'h00},
            '{STEP_WRITE, rc4_pkg::CFG_KEY_THIRD,  '1,          8'h00, 1'b0, 1'b0, 8'h00},
            '{STEP_WRITE, rc4_pkg::CFG_KEY_HIGH,   '1,          8'h00, 1'b0, 1'b0, 8'h00},
            '{STEP_WRITE, rc4_pkg::CFG_KEY_LENGTH, 64'(rc4_pkg::MAX_KEY_BYTES),
                                                                8'h00, 1'b0, 1'b0, 8'h00},
            '{STEP_BYTE,  rc4_pkg::CFG_KEY_LOW,    64'h0,       8'hFF, 1'b1, 1'b0, 8'h00},
            '{STEP_BYTE,  rc4_pkg::CFG_KEY_LOW,    64'h0,       8'h00, 1'b0, 1'b0, 8'h00},
            // A key length of zero acts as a length of one.
            '{STEP_WRITE, rc4_pkg::CFG_KEY_LENGTH, 64'd0,       8'h00, 1'b0, 1'b0, 8'h00},
            '{STEP_BYTE,  rc4_pkg::CFG_KEY_LOW,    64'h0,       8'h00, 1'b1, 1'b0, 8'h00},
            // The largest length the field holds saturates to the key store size.
            '{STEP_WRITE, rc4_pkg::CFG_KEY_LENGTH, 64'h3F,      8'h00, 1'b0, 1'b0, 8'h00},
            '{STEP_BYTE,  rc4_pkg::CFG_KEY_LOW,    64'h0,       8'hA5, 1'b1, 1'b0, 8'h00},
            '{STEP_BYTE,  rc4_pkg::CFG_KEY_LOW,    64'h0,       8'h3C, 1'b0, 1'b0, 8'h00},
            // Writes past the register list are dropped.
            '{STEP_WRITE, CFG_SPARE_FIRST,         64'h1,       8'h00, 1'b0, 1'b0, 8'h00},
            '{STEP_WRITE, CFG_SPARE_LAST,          64'h1F,      8'h00, 1'b0, 1'b0, 8'h00},
            '{STEP_BYTE,  rc4_pkg::CFG_KEY_LOW,    64'h0,       8'h00, 1'b1, 1'b0, 8'h00}
        };

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(negedge aclk);

        foreach (directed_tab[r]) begin
            row = directed_tab[r];
            if (row.kind == STEP_WRITE)
                write_reg(row.reg_idx, row.reg_val);
            else
                push_byte(row.din, row.som, row.dout, row.known, 1'b0);
        end

        // Random part: mostly well-formed messages (a keyed first byte, then a run of
        // plain bytes), with the occasional stray start flag or a message that just
        // carries on the previous keystream. Key changes fall between messages.
        while (rnd_done < RANDOM_ITEMS) begin
            quiet     = (rnd_done >= RANDOM_ITEMS - QUIET_ITEMS);
            gaps      = !quiet && ($urandom_range(0, 3) != 0);
            rx_stalls = gaps;

            if ($urandom_range(0, 2) == 0) begin
                repeat ($urandom_range(1, 3)) begin
                    idx = rc4_pkg::CFG_IDX_W'($urandom_range(0,
                                                             (1 << rc4_pkg::CFG_IDX_W) - 1));
                    case ($urandom_range(0, 5))
                        0:       val = '0;
                        1:       val = '1;
                        default: val = {$urandom, $urandom};
                    endcase
                    if (idx == rc4_pkg::CFG_KEY_LENGTH) begin
                        case ($urandom_range(0, 5))
                            0:       len_pick = 0;
                            1:       len_pick = 1;
                            2:       len_pick = rc4_pkg::MAX_KEY_BYTES;
                            3:       len_pick = $urandom_range(rc4_pkg::MAX_KEY_BYTES + 1,
                                                               (1 << rc4_pkg::KEY_LEN_W) - 1);
                            default: len_pick = $urandom_range(1, rc4_pkg::MAX_KEY_BYTES);
                        endcase
                        val[rc4_pkg::KEY_LEN_W-1:0] = len_pick[rc4_pkg::KEY_LEN_W-1:0];
                    end
                    write_reg(idx, val);
                end
            end

            msg_len   = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                    : $urandom_range(1, 12);
            first_som = ($urandom_range(0, 9) != 0);

            // Once per run the receiver stops for a long stretch in the middle of a long,
            // gapless message, so the block fills and stalls its input.
            pressure_phase = 1'b0;
            if (!pressure_done && rnd_done >= HOLD_AT_ITEM) begin
                pressure_done  = 1'b1;
                pressure_phase = 1'b1;
                gaps           = 1'b0;
                msg_len        = 48;
                first_som      = 1'b1;
            end

            for (int k = 0; k < msg_len && rnd_done < RANDOM_ITEMS; k++) begin
                som = (k == 0) ? first_som : ($urandom_range(0, 39) == 0);
                // Arm the hold past the first bytes so the key schedule is over by then.
                if (pressure_phase && k == 2)
                    pressure_arm = 1'b1;
                push_byte(8'($urandom_range(0, 255)), som, 8'h00, 1'b0, gaps);
                rnd_done++;
            end
        end

        s_tvalid <= 1'b0;
        while (pending_out.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Receiver: m_tready changes only at the falling edge. It stalls in short random
    // bursts while stalls are enabled, and holds off for a long count when asked.
    initial begin
        int stall_left;
        int hold_left;
        m_tready   = 1'b0;
        stall_left = 0;
        hold_left  = 0;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (rx_stalls && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 8) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Every output transfer is matched against the oldest owed byte.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_out.size() == 0) begin
                report_fail($sformatf("output byte %02h with nothing outstanding", m_tdata));
            end else begin
                want_byte = pending_out.pop_front();
                if (m_tdata !== want_byte)
                    report_fail($sformatf("out_byte mismatch: expected %02h, got %02h",
                                          want_byte, m_tdata));
            end
        end
    end

    // Watchdog against a hung handshake.
    initial cycle_count = 0;
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

endmodule
